// ===== rtl/lrd_pkg.sv =====
// Package for the ranged random draw core: generator constants, pipeline
// widths and the beat record that moves from cell to cell.
// No dependencies.
package lrd_pkg;

  // Linear congruential step: next = seed * LCG_MUL + LCG_ADD (mod 2^32)
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  localparam int SEED_W    = 32;
  localparam int BOUND_W   = 32;
  localparam int RAW_W     = 31;
  localparam int SLICE_LSB = 16;
  localparam int FIRST_W   = 11;
  localparam int NEXT_W    = 10;

  // Generator steps, then one reduction cell per raw bit
  localparam int LCG_CELLS = 3;
  localparam int MOD_CELLS = RAW_W;
  localparam int CELLS     = LCG_CELLS + MOD_CELLS;

  // Data carried by every cell of the chain
  typedef struct packed {
    logic [SEED_W-1:0]  seed;   // generator state
    logic [BOUND_W-1:0] bound;  // exclusive range bound
    logic [RAW_W-1:0]   raw;    // raw bits, still to be reduced from the top
    logic [RAW_W-1:0]   rem;    // partial remainder
  } beat_t;

endpackage

// ===== rtl/lcg_ranged_random_draw_core.sv =====
// Top level of the ranged random draw core: a chain of generator cells
// followed by remainder cells. Depends on lrd_pkg, lrd_lcg_cell, lrd_mod_cell.
//
//  channel | direction | tdata                               | tuser
//  --------+-----------+-------------------------------------+-------------
//  in_     | slave     | [31:0] seed_in, [63:32] range_max   | none
//  out_    | master    | [30:0] value, [62:31] seed_out, pad | range_error
//
// Takes one beat per cycle while the output is not stalled; each draw passes
// through the three congruential cells, then one remainder cell per raw bit
// in the 31-cell remainder chain.
// Every cell holds its own valid bit, so a stalled output only blocks the
// cells behind a full one; bubbles close up while the result waits.
// Reset (rst_n low, synchronous) empties the chain; there is no stored state.
module lcg_ranged_random_draw_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] seed_in, [63:32] range_max
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [30:0] value, [62:31] seed_out, [63] zero
  output logic        out_tuser   // [0] range_error
);

  logic           node_valid [lrd_pkg::CELLS+1];
  logic           node_ready [lrd_pkg::CELLS+1];
  lrd_pkg::beat_t node_beat  [lrd_pkg::CELLS+1];
  lrd_pkg::beat_t last_beat;
  logic           zero_bound;

  // Unpack the input beat into the head of the chain
  assign node_valid[0]       = in_tvalid;
  assign in_tready           = node_ready[0];
  assign node_beat[0].seed   = in_tdata[31:0];
  assign node_beat[0].bound  = in_tdata[63:32];
  assign node_beat[0].raw    = '0;
  assign node_beat[0].rem    = '0;

  // Generator cells
  for (genvar g = 0; g < lrd_pkg::LCG_CELLS; g++) begin : g_lcg
    lrd_lcg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .first_i  (g == 0),
      .up_valid (node_valid[g]),
      .up_ready (node_ready[g]),
      .up_beat  (node_beat[g]),
      .dn_valid (node_valid[g+1]),
      .dn_ready (node_ready[g+1]),
      .dn_beat  (node_beat[g+1])
    );
  end

  // Remainder cells, one per raw bit, most significant first
  for (genvar m = lrd_pkg::LCG_CELLS; m < lrd_pkg::CELLS; m++) begin : g_mod
    lrd_mod_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (node_valid[m]),
      .up_ready (node_ready[m]),
      .up_beat  (node_beat[m]),
      .dn_valid (node_valid[m+1]),
      .dn_ready (node_ready[m+1]),
      .dn_beat  (node_beat[m+1])
    );
  end

  // Drive the result from the last cell; a zero bound forces value to zero
  assign last_beat                = node_beat[lrd_pkg::CELLS];
  assign zero_bound               = (last_beat.bound == '0);
  assign out_tvalid               = node_valid[lrd_pkg::CELLS];
  assign node_ready[lrd_pkg::CELLS] = out_tready;
  assign out_tdata[30:0]          = zero_bound ? '0 : last_beat.rem;
  assign out_tdata[62:31]         = last_beat.seed;
  assign out_tdata[63]            = 1'b0;
  assign out_tuser                = zero_bound;

endmodule

// ===== rtl/lrd_lcg_cell.sv =====
// One generator cell: advances the seed by one congruential step and
// appends its bit slice to the raw value. Depends on lrd_pkg.
module lrd_lcg_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          first_i,     // tie high on the cell that takes the wide slice
  input  logic          up_valid,
  output logic          up_ready,
  input  lrd_pkg::beat_t up_beat,
  output logic          dn_valid,
  input  logic          dn_ready,
  output lrd_pkg::beat_t dn_beat
);

  logic           valid_r;
  lrd_pkg::beat_t beat_r;
  lrd_pkg::beat_t beat_nxt;
  logic [31:0]    seed_step;

  // Take a new beat when empty or when the neighbor takes ours
  assign up_ready = !valid_r || dn_ready;

  // Advance the seed and append the slice
  always_comb begin
    seed_step      = 32'(up_beat.seed * lrd_pkg::LCG_MUL) + lrd_pkg::LCG_ADD;
    beat_nxt       = up_beat;
    beat_nxt.seed  = seed_step;
    if (first_i) begin
      beat_nxt.raw = lrd_pkg::RAW_W'(
        seed_step[lrd_pkg::SLICE_LSB +: lrd_pkg::FIRST_W]);
    end else begin
      beat_nxt.raw = {up_beat.raw[lrd_pkg::RAW_W-lrd_pkg::NEXT_W-1:0],
                      seed_step[lrd_pkg::SLICE_LSB +: lrd_pkg::NEXT_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

endmodule

// ===== rtl/lrd_mod_cell.sv =====
// One reduction cell: a restoring remainder step that shifts in the next raw
// bit and subtracts the bound when it fits. Depends on lrd_pkg.
module lrd_mod_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  lrd_pkg::beat_t up_beat,
  output logic          dn_valid,
  input  logic          dn_ready,
  output lrd_pkg::beat_t dn_beat
);

  logic              valid_r;
  lrd_pkg::beat_t    beat_r;
  lrd_pkg::beat_t    beat_nxt;
  logic [lrd_pkg::BOUND_W-1:0] shifted;
  logic [lrd_pkg::BOUND_W-1:0] diff;

  assign up_ready = !valid_r || dn_ready;

  // Shift the top raw bit into the remainder, subtract the bound if it fits.
  // A zero bound always subtracts nothing, so the remainder follows the raw bits.
  always_comb begin
    shifted  = {1'b0, up_beat.rem[lrd_pkg::RAW_W-2:0], up_beat.raw[lrd_pkg::RAW_W-1]};
    diff     = shifted - up_beat.bound;
    beat_nxt = up_beat;
    beat_nxt.raw = {up_beat.raw[lrd_pkg::RAW_W-2:0], 1'b0};
    if (shifted >= up_beat.bound) begin
      beat_nxt.rem = diff[lrd_pkg::RAW_W-1:0];
    end else begin
      beat_nxt.rem = shifted[lrd_pkg::RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

endmodule

// ===== bench/lcg_ranged_random_draw_core_tb.sv =====
// Self-checking bench for lcg_ranged_random_draw_core: drives seed/bound beats,
// predicts each draw independently and compares every output beat in order.
// Depends on the RTL top level only (and its lrd_pkg through the instance).
module lcg_ranged_random_draw_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] STEP_MUL    = 32'd1103515245;
  localparam logic [31:0] STEP_ADD    = 32'd12345;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 80;
  localparam int          CYCLE_LIMIT = 200000;

  // One predicted draw
  typedef struct {
    logic [30:0] value;
    logic [31:0] seed;
    logic        range_error;
  } draw_t;

  // Keeps predicted draws in acceptance order and checks output beats
  class draw_checker;
    draw_t       pending_draws[$];
    logic [31:0] newest_seed;
    int          errors;

    function new();
      errors      = 0;
      newest_seed = 32'd0;
    endfunction

    // Three congruential steps, slice join, then reduce by the bound
    function draw_t draw_from_seed(logic [31:0] seed, logic [31:0] bound);
      logic [31:0] s1, s2, s3, rem;
      logic [30:0] raw;
      draw_t       d;
      s1  = seed * STEP_MUL + STEP_ADD;
      s2  = s1 * STEP_MUL + STEP_ADD;
      s3  = s2 * STEP_MUL + STEP_ADD;
      raw = {s1[26:16], s2[25:16], s3[25:16]};
      if (bound == 32'd0) begin
        d.value       = 31'd0;
        d.range_error = 1'b1;
      end else begin
        rem           = {1'b0, raw} % bound;
        d.value       = rem[30:0];
        d.range_error = 1'b0;
      end
      d.seed = s3;
      return d;
    endfunction

    function void note_draw(logic [63:0] tdata);
      draw_t d;
      d = draw_from_seed(tdata[31:0], tdata[63:32]);
      newest_seed = d.seed;
      pending_draws.push_back(d);
    endfunction

    function void check_result(logic [63:0] tdata, logic tuser);
      draw_t d;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected output beat tdata=%h tuser=%b", $time, tdata, tuser);
        errors++;
        return;
      end
      d = pending_draws.pop_front();
      if (tdata[30:0] !== d.value) begin
        $display("%0t: value expected %h actual %h", $time, d.value, tdata[30:0]);
        errors++;
      end
      if (tdata[62:31] !== d.seed) begin
        $display("%0t: seed_out expected %h actual %h", $time, d.seed, tdata[62:31]);
        errors++;
      end
      if (tdata[63] !== 1'b0) begin
        $display("%0t: pad bit expected 0 actual %b", $time, tdata[63]);
        errors++;
      end
      if (tuser !== d.range_error) begin
        $display("%0t: range_error expected %b actual %b", $time, d.range_error, tuser);
        errors++;
      end
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] seed_in, [63:32] range_max
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [30:0] value, [62:31] seed_out, [63] zero
  logic        out_tuser;  // [0] range_error

  draw_checker sb;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_req;
  int          hold_left;
  int          cycle_count;

  lcg_ranged_random_draw_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Note accepted input beats, check accepted output beats
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_draw(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lcg_ranged_random_draw_core verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted here when requested
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one beat, idling at random first; return once it is taken
  task automatic send_draw(input logic [31:0] seed, input logic [31:0] bound);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bound, seed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold off until every predicted draw has come out
  task automatic drain_draws();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mix of bound classes: zero, tiny, powers of two, above the raw range, shifted down, just under 2^31, full
  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom_range(1, 16);
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return 32'h8000_0000 | $urandom;
      4:       return $urandom >> $urandom_range(0, 31);
      5:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_v);
    logic [31:0] seed;
    send_idle_pct = idle_pct;
    stall_pct     = stall_v;
    for (int i = 0; i < n; i++) begin
      // Chain the stream's own seed most of the time, as a real user would
      if ($urandom_range(0, 3) != 0) seed = sb.newest_seed;
      else seed = $urandom;
      send_draw(seed, pick_bound());
    end
    drain_draws();
  endtask

  logic [31:0] dir_seeds[20];
  logic [31:0] dir_bounds[20];

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 64'd0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    cycle_count   = 0;

    // Extremes of seed and bound, zero bound, bounds around 2^31
    dir_seeds  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'h0000_FFFF, 32'hFFFF_0000,
                   32'h0BAD_F00D, 32'hCAFE_D00D, 32'h0000_0000, 32'hFFFF_FFFF};
    dir_bounds = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                   32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h0000_0001,
                   32'h0000_0003, 32'h0001_0000, 32'h0000_0400, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h0000_000A, 32'h4000_0000, 32'h8000_0000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats, no idling
    foreach (dir_seeds[i]) send_draw(dir_seeds[i], dir_bounds[i]);
    drain_draws();

    // Random phases across idle and stall mixes
    run_phase(260, 0, 0);
    run_phase(250, 65, 0);
    run_phase(250, 0, 65);
    run_phase(250, 22, 22);

    // Long receiver hold-off while the sender keeps offering: fill the chain
    hold_req = 1'b1;
    run_phase(120, 0, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("lcg_ranged_random_draw_core verification clean");
    else
      $display("lcg_ranged_random_draw_core verification failed");
    $finish;
  end

endmodule
